// ===== rtl/fsnp_pkg.sv =====
// Shared types, constants and a helper function of the format string number printer.
package fsnp_pkg;

   // Character and value widths.
   localparam int unsigned CharWidth  = 8;
   localparam int unsigned ValueWidth = 64;

   // Digit buffer: twenty BCD digits cover every 64-bit value.
   localparam int unsigned NumDigits  = 20;
   localparam int unsigned DigitWidth = 4;
   localparam int unsigned DigBufWidth = NumDigits * DigitWidth;
   localparam int unsigned HexDigits  = ValueWidth / DigitWidth;
   localparam int unsigned HexPad     = DigBufWidth - ValueWidth;

   // Characters with a special meaning in the format stream.
   localparam logic [CharWidth-1:0] CharNul     = 8'h00;
   localparam logic [CharWidth-1:0] CharPercent = 8'h25;
   localparam logic [CharWidth-1:0] CharDec     = 8'h64;
   localparam logic [CharWidth-1:0] CharHex     = 8'h68;
   localparam logic [CharWidth-1:0] CharZero    = 8'h30;
   localparam logic [CharWidth-1:0] CharX       = 8'h78;

   // Offset from a digit value of ten or more to its lowercase letter.
   localparam logic [CharWidth-1:0] LetterBase  = 8'h57;

   typedef logic [DigBufWidth-1:0] dig_buf_type;

   // Map one digit to its ASCII character from "0123456789abcdef".
   function automatic logic [CharWidth-1:0] digit_char(input logic [DigitWidth-1:0] d);
      logic [CharWidth-1:0] ext;
      ext = {{(CharWidth-DigitWidth){1'b0}}, d};
      if (d < 4'd10) begin
         return CharZero + ext;
      end else begin
         return LetterBase + ext;
      end
   endfunction

endpackage

// ===== rtl/fsnp_dabble.sv =====
// One shift-add-3 step of the binary to BCD converter over the whole digit buffer.
module fsnp_dabble (
   input  fsnp_pkg::dig_buf_type dig_i,
   input  logic                  bit_i,
   output fsnp_pkg::dig_buf_type dig_o
);

   fsnp_pkg::dig_buf_type adj;

   // Each digit of five or more gets three added before the shift.
   always_comb begin
      for (int i = 0; i < int'(fsnp_pkg::NumDigits); i++) begin
         if (dig_i[i*fsnp_pkg::DigitWidth +: fsnp_pkg::DigitWidth] >= 4'd5) begin
            adj[i*fsnp_pkg::DigitWidth +: fsnp_pkg::DigitWidth] =
               dig_i[i*fsnp_pkg::DigitWidth +: fsnp_pkg::DigitWidth] + 4'd3;
         end else begin
            adj[i*fsnp_pkg::DigitWidth +: fsnp_pkg::DigitWidth] =
               dig_i[i*fsnp_pkg::DigitWidth +: fsnp_pkg::DigitWidth];
         end
      end
   end

   // Shift the adjusted buffer left and bring in the next binary bit.
   assign dig_o = {adj[fsnp_pkg::DigBufWidth-2:0], bit_i};

endmodule

// ===== rtl/format_string_number_printer.sv =====
// Top level of the format string number printer: sequencer, converter and output register.
//
//   Channel   Direction  Payload
//   req_*     in         tdata[7:0] fmt_char, tdata[71:8] value
//   rsp_*     out        tdata[7:0] out_char, tlast marks the final character of a request
//
// An ordinary character is passed through; a '%', a terminator or a dropped selector emits nothing.
// A %h request emits the "0x" prefix and then walks the sixteen hex digits of the value.
// A %d request shifts all 64 value bits through the shared shift-add-3 converter step and
// then walks the twenty BCD digits of the result.
// A stalled result holds the sequencer; leading zeros are skipped without waiting for the output.
// Reset is synchronous and clears the escape flag, the sequencer and the output valid.
module format_string_number_printer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // [7:0] fmt_char, [71:8] value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_char
   output logic        rsp_tlast
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CONV   = 4'b0010,
      ST_PREFIX = 4'b0100,
      ST_DIGITS = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;
   logic                      pct_ff, pct_in;
   logic [63:0]               bin_ff, bin_in;
   logic [5:0]                cnt_ff, cnt_in;
   fsnp_pkg::dig_buf_type     dig_ff, dig_in;
   fsnp_pkg::dig_buf_type     dab_out;
   logic [4:0]                left_ff, left_in;
   logic                      started_ff, started_in;
   logic                      pfx_ff, pfx_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [7:0]                rsp_char_ff, rsp_char_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      out_free;
   logic                      req_acc;
   logic                      emit;
   logic [7:0]                emit_char;
   logic                      emit_last;
   logic [7:0]                fmt_char;
   logic [63:0]               value;
   logic [3:0]                top_digit;

   assign fmt_char  = req_tdata[7:0];
   assign value     = req_tdata[71:8];
   assign top_digit = dig_ff[fsnp_pkg::DigBufWidth-1 -: fsnp_pkg::DigitWidth];

   // The output register can take a new character when empty or being drained.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_acc    = req_tvalid && req_tready;

   // Shared shift-add-3 step used once per converter cycle.
   fsnp_dabble u_dabble (
      .dig_i (dig_ff),
      .bit_i (bin_ff[63]),
      .dig_o (dab_out)
   );

   // Sequencer: decodes a request, runs the converter, emits the hex prefix and walks the digits.
   always_comb begin
      state_in   = state_ff;
      pct_in     = pct_ff;
      bin_in     = bin_ff;
      cnt_in     = cnt_ff;
      dig_in     = dig_ff;
      left_in    = left_ff;
      started_in = started_ff;
      pfx_in     = pfx_ff;
      emit       = 1'b0;
      emit_char  = fmt_char;
      emit_last  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               priority if (fmt_char == fsnp_pkg::CharNul) begin
                  pct_in = 1'b0;
               end else if (pct_ff) begin
                  pct_in = 1'b0;
                  if (fmt_char == fsnp_pkg::CharDec) begin
                     bin_in   = value;
                     cnt_in   = '0;
                     dig_in   = '0;
                     state_in = ST_CONV;
                  end else if (fmt_char == fsnp_pkg::CharHex) begin
                     dig_in   = {value, {fsnp_pkg::HexPad{1'b0}}};
                     left_in  = 5'(fsnp_pkg::HexDigits);
                     started_in = 1'b0;
                     pfx_in   = 1'b0;
                     state_in = ST_PREFIX;
                  end
               end else if (fmt_char == fsnp_pkg::CharPercent) begin
                  pct_in = 1'b1;
               end else begin
                  emit      = 1'b1;
                  emit_char = fmt_char;
                  emit_last = 1'b1;
               end
            end
         end
         ST_CONV: begin
            dig_in = dab_out;
            bin_in = {bin_ff[62:0], 1'b0};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               left_in    = 5'(fsnp_pkg::NumDigits);
               started_in = 1'b0;
               state_in   = ST_DIGITS;
            end
         end
         ST_PREFIX: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_char = pfx_ff ? fsnp_pkg::CharX : fsnp_pkg::CharZero;
               pfx_in    = 1'b1;
               if (pfx_ff) begin
                  state_in = ST_DIGITS;
               end
            end
         end
         ST_DIGITS: begin
            // Leading zeros are dropped, but the last digit always prints.
            if (started_ff || top_digit != 4'd0 || left_ff == 5'd1) begin
               if (out_free) begin
                  emit       = 1'b1;
                  emit_char  = fsnp_pkg::digit_char(top_digit);
                  emit_last  = (left_ff == 5'd1);
                  started_in = 1'b1;
                  dig_in     = {dig_ff[fsnp_pkg::DigBufWidth-fsnp_pkg::DigitWidth-1:0],
                                {fsnp_pkg::DigitWidth{1'b0}}};
                  left_in    = left_ff - 5'd1;
                  if (left_ff == 5'd1) begin
                     state_in = ST_IDLE;
                  end
               end
            end else begin
               dig_in  = {dig_ff[fsnp_pkg::DigBufWidth-fsnp_pkg::DigitWidth-1:0],
                          {fsnp_pkg::DigitWidth{1'b0}}};
               left_in = left_ff - 5'd1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register next value.
   always_comb begin
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = emit_char;
         rsp_last_in  = emit_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pct_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pct_ff       <= pct_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      bin_ff      <= bin_in;
      cnt_ff      <= cnt_in;
      dig_ff      <= dig_in;
      left_ff     <= left_in;
      started_ff  <= started_in;
      pfx_ff      <= pfx_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;

   // The sequencer is always in exactly one state.
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state is not one-hot");

   // Nothing is offered while the converter runs.
   a_conv_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV) |-> !rsp_tvalid)
      else $error("result offered during conversion");

   // The digit walk never runs out of digits before the last one prints.
   a_digits_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGITS) |-> (left_ff != 5'd0))
      else $error("digit walk has no digits left");

   // A new request is only taken after the previous one has finished.
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> (state_ff == ST_IDLE))
      else $error("request accepted while busy");

endmodule
